// ===== rtl/core/rcrs_pkg.sv =====
// shared constants, codes and types of the rc reflectance sensor scanner
package rcrs_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int COUNT_WIDTH = 16;

  localparam int IDX_W    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int CFG_W    = 16;
  localparam int CMP_W    = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam int SAMPLE_W = 16;
  localparam int OUT_IDX_W = 3;
  localparam int MAP_W    = 8;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] PRECHARGE_RST       = CFG_W'(10);
  localparam logic [CFG_W-1:0] BLACK_THRESHOLD_RST = CFG_W'(1500);

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_THRESHOLD = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_START     = 2'd1,
    PH_CHARGE    = 2'd2,
    PH_DISCHARGE = 2'd3
  } phase_t;

  typedef struct packed {
    logic                   we;
    logic [IDX_W-1:0]       idx;
    logic [COUNT_WIDTH-1:0] value;
  } store_wr_t;

  typedef struct packed {
    logic                 pin_drive_enable;
    logic [OUT_IDX_W-1:0] sensor_index;
    logic                 led_on;
    logic                 sample_valid;
    logic [SAMPLE_W-1:0]  sample_value;
  } scan_status_t;

endpackage

// ===== rtl/core/rcrs_ctrl.sv =====
// scan sequencer: phase, sensor index, discharge counter and led state
module rcrs_ctrl import rcrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic               in_pin_level,
  input  logic [CFG_W-1:0]   precharge,
  input  logic [CFG_W-1:0]   black_threshold,
  output store_wr_t          store_wr,
  output scan_status_t       status_nxt
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [IDX_W-1:0]       IDX_LAST  = IDX_W'(NUM_SENSORS - 1);

  phase_t                 phase_r, phase_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   run_r, run_nxt;
  logic                   led_r, led_nxt;
  logic                   smp_valid;
  logic                   charge_done;
  logic                   timeout;

  assign charge_done = CMP_W'(count_r) >= CMP_W'(precharge);
  assign timeout     = CMP_W'(count_r) >= CMP_W'(black_threshold);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    run_nxt   = run_r;
    led_nxt   = led_r;
    smp_valid = 1'b0;
    unique case (in_opcode)
      OP_TICK: begin
        if (phase_r == PH_START) begin
          phase_nxt = PH_CHARGE;
          count_nxt = '0;
          run_nxt   = 1'b1;
        end else if (phase_r == PH_CHARGE && charge_done) begin
          phase_nxt = PH_DISCHARGE;
          count_nxt = '0;
        end else if (phase_r == PH_DISCHARGE && (!in_pin_level || timeout)) begin
          smp_valid = 1'b1;
          run_nxt   = 1'b0;
          phase_nxt = PH_START;
          idx_nxt   = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
        end
        if (run_nxt && count_nxt != COUNT_MAX) begin
          count_nxt = count_nxt + 1'b1;
        end
      end
      OP_START: begin
        phase_nxt = PH_START;
        idx_nxt   = '0;
        count_nxt = '0;
        run_nxt   = 1'b0;
        led_nxt   = 1'b1;
      end
      OP_STOP: begin
        phase_nxt = PH_IDLE;
        count_nxt = '0;
        run_nxt   = 1'b0;
        led_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    store_wr.we    = in_accept && smp_valid;
    store_wr.idx   = idx_r;
    store_wr.value = count_r;

    status_nxt.pin_drive_enable = (phase_nxt == PH_CHARGE);
    status_nxt.sensor_index     = OUT_IDX_W'(idx_nxt);
    status_nxt.led_on           = led_nxt;
    status_nxt.sample_valid     = smp_valid;
    status_nxt.sample_value     = smp_valid ? SAMPLE_W'(count_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      count_r <= '0;
      run_r   <= 1'b0;
      led_r   <= 1'b0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
      run_r   <= run_nxt;
      led_r   <= led_nxt;
    end
  end

`ifndef SYNTHESIS
  a_run_only_when_measuring: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (phase_r == PH_CHARGE || phase_r == PH_DISCHARGE))
    else $error("counter running outside charge or discharge");

  a_idle_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> !run_r && count_r == '0)
    else $error("idle phase with live counter");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_LAST)
    else $error("sensor index out of range");

  a_sample_wraps_to_start: assert property (@(posedge clk) disable iff (!rst_n)
    store_wr.we |=> phase_r == PH_START && !run_r)
    else $error("finished sample did not return to start phase");
`endif

endmodule

// ===== rtl/core/rcrs_store.sv =====
// per-sensor discharge count store and black map compare
module rcrs_store import rcrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  store_wr_t        store_wr,
  input  logic [CFG_W-1:0] black_threshold,
  output logic [MAP_W-1:0] black_map_nxt
);

  logic [COUNT_WIDTH-1:0] stored_r [NUM_SENSORS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        stored_r[i] <= '0;
      end
    end else if (store_wr.we) begin
      stored_r[store_wr.idx] <= store_wr.value;
    end
  end

  for (genvar g = 0; g < MAP_W; g++) begin : g_map
    if (g < NUM_SENSORS) begin : g_live
      logic [COUNT_WIDTH-1:0] val;
      assign val = (store_wr.we && store_wr.idx == IDX_W'(g)) ? store_wr.value
                                                              : stored_r[g];
      assign black_map_nxt[g] = CMP_W'(val) >= CMP_W'(black_threshold);
    end else begin : g_absent
      assign black_map_nxt[g] = 1'b0;
    end
  end

endmodule

// ===== rtl/core/rc_reflectance_sensor_scanner_unit.sv =====
// top level of the rc reflectance sensor scanner: config, handshake, result register
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/in_stall   | in_opcode, in_pin_level
//  out_    | output    | out_valid/out_stall | pin drive, index, led, sample, black map
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  one transaction per cycle while in_stall is low; its result appears in the cycle after acceptance
//  the result register is the only pipeline stage, set by the sequencer and compare logic
//  reset restores precharge 10, black_threshold 1500, idle phase and a zeroed store
//  in_stall follows out_stall while a result is held; cfg_ready is always high
module rc_reflectance_sensor_scanner_unit import rcrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic                 in_pin_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_pin_drive_enable,
  output logic [OUT_IDX_W-1:0] out_sensor_index,
  output logic                 out_led_on,
  output logic                 out_sample_valid,
  output logic [SAMPLE_W-1:0]  out_sample_value,
  output logic [MAP_W-1:0]     out_black_map,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] precharge_r;
  logic [CFG_W-1:0] black_threshold_r;
  logic             in_accept;
  store_wr_t        store_wr;
  scan_status_t     status_nxt;
  scan_status_t     status_r;
  logic [MAP_W-1:0] black_map_nxt;
  logic [MAP_W-1:0] black_map_r;
  logic             out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precharge_r       <= PRECHARGE_RST;
      black_threshold_r <= BLACK_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PRECHARGE:       precharge_r       <= cfg_data;
        REG_BLACK_THRESHOLD: black_threshold_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rcrs_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_accept       (in_accept),
    .in_opcode       (in_opcode),
    .in_pin_level    (in_pin_level),
    .precharge       (precharge_r),
    .black_threshold (black_threshold_r),
    .store_wr        (store_wr),
    .status_nxt      (status_nxt)
  );

  rcrs_store u_store (
    .clk             (clk),
    .rst_n           (rst_n),
    .store_wr        (store_wr),
    .black_threshold (black_threshold_r),
    .black_map_nxt   (black_map_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      status_r    <= status_nxt;
      black_map_r <= black_map_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_pin_drive_enable = status_r.pin_drive_enable;
  assign out_sensor_index     = status_r.sensor_index;
  assign out_led_on           = status_r.led_on;
  assign out_sample_valid     = status_r.sample_valid;
  assign out_sample_value     = status_r.sample_value;
  assign out_black_map        = black_map_r;

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_opcode == OP_START |=>
      out_led_on && out_sensor_index == '0 && !out_pin_drive_enable && !out_sample_valid)
    else $error("start did not restart the scan");

  a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_opcode == OP_STOP |=> !out_led_on && !out_pin_drive_enable)
    else $error("stop left led or pin drive on");

  a_sample_not_driving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_valid |-> !out_pin_drive_enable)
    else $error("sample reported while pin driven");

  a_no_sample_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_valid |-> out_sample_value == '0)
    else $error("sample value without sample");
`endif

endmodule

// ===== bench/rcrs_scan_checker.sv =====
`timescale 1ns / 1ps
// result checker for the rc reflectance sensor scanner: predicts each transaction and compares
module rcrs_scan_checker import rcrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic                 in_pin_level,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_pin_drive_enable,
  input  logic [OUT_IDX_W-1:0] out_sensor_index,
  input  logic                 out_led_on,
  input  logic                 out_sample_valid,
  input  logic [SAMPLE_W-1:0]  out_sample_value,
  input  logic [MAP_W-1:0]     out_black_map,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    scan_status_t     status;
    logic [MAP_W-1:0] black_map;
  } scan_result_t;

  logic [CFG_W-1:0]       precharge;
  logic [CFG_W-1:0]       black_threshold;
  phase_t                 scan_phase;
  logic [IDX_W-1:0]       sensor;
  logic [COUNT_WIDTH-1:0] discharge_count;
  logic                   counting;
  logic                   led;
  logic [COUNT_WIDTH-1:0] sensor_counts [NUM_SENSORS];
  scan_result_t           expected_scans [$];

  task automatic predict_scan(input logic [OP_W-1:0] op, input logic pin);
    scan_result_t r;
    r = '0;
    case (op)
      OP_TICK: begin
        if (scan_phase == PH_START) begin
          scan_phase = PH_CHARGE;
          discharge_count = '0;
          counting = 1'b1;
        end else if (scan_phase == PH_CHARGE && discharge_count >= precharge) begin
          scan_phase = PH_DISCHARGE;
          discharge_count = '0;
        end else if (scan_phase == PH_DISCHARGE &&
                     (!pin || discharge_count >= black_threshold)) begin
          sensor_counts[sensor] = discharge_count;
          r.status.sample_valid = 1'b1;
          r.status.sample_value = SAMPLE_W'(discharge_count);
          counting = 1'b0;
          scan_phase = PH_START;
          sensor = (sensor == IDX_W'(NUM_SENSORS - 1)) ? '0 : sensor + 1'b1;
        end
        if (counting && discharge_count != '1)
          discharge_count = discharge_count + 1'b1;
      end
      OP_START: begin
        scan_phase = PH_START;
        sensor = '0;
        discharge_count = '0;
        counting = 1'b0;
        led = 1'b1;
      end
      OP_STOP: begin
        scan_phase = PH_IDLE;
        discharge_count = '0;
        counting = 1'b0;
        led = 1'b0;
      end
      default: ;
    endcase
    r.status.pin_drive_enable = (scan_phase == PH_CHARGE);
    r.status.sensor_index = OUT_IDX_W'(sensor);
    r.status.led_on = led;
    for (int i = 0; i < NUM_SENSORS && i < MAP_W; i++)
      r.black_map[i] = (sensor_counts[i] >= black_threshold);
    expected_scans.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    scan_result_t want;
    if (!rst_n) begin
      precharge = PRECHARGE_RST;
      black_threshold = BLACK_THRESHOLD_RST;
      scan_phase = PH_IDLE;
      sensor = '0;
      discharge_count = '0;
      counting = 1'b0;
      led = 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++)
        sensor_counts[i] = '0;
      expected_scans.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_scans.size() == 0) begin
          fail_count++;
          $display("%0t: result with no transaction waiting, expected none, got sensor %0d",
                   $time, out_sensor_index);
        end else begin
          want = expected_scans.pop_front();
          check_field("pin_drive_enable", 32'(want.status.pin_drive_enable),
                      32'(out_pin_drive_enable));
          check_field("sensor_index", 32'(want.status.sensor_index),
                      32'(out_sensor_index));
          check_field("led_on", 32'(want.status.led_on), 32'(out_led_on));
          check_field("sample_valid", 32'(want.status.sample_valid),
                      32'(out_sample_valid));
          check_field("sample_value", 32'(want.status.sample_value),
                      32'(out_sample_value));
          check_field("black_map", 32'(want.black_map), 32'(out_black_map));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRECHARGE:       precharge = cfg_data;
          REG_BLACK_THRESHOLD: black_threshold = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_scan(in_opcode, in_pin_level);
    end
    pending = expected_scans.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// top of the rc reflectance sensor scanner bench: clock, reset, stimulus and verdict
module tb_top;
  import rcrs_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_SETTING = 165;
  localparam int SETTINGS_COUNT = 7;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode = OP_TICK;
  logic                 in_pin_level = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_pin_drive_enable;
  logic [OUT_IDX_W-1:0] out_sensor_index;
  logic                 out_led_on;
  logic                 out_sample_valid;
  logic [SAMPLE_W-1:0]  out_sample_value;
  logic [MAP_W-1:0]     out_black_map;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PRECHARGE;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   fail_count;
  int                   pending;
  bit                   idling = 1'b1;
  int                   cycle_count = 0;

  rc_reflectance_sensor_scanner_unit dut (.*);

  rcrs_scan_checker checker_i (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rc_reflectance_sensor_scanner_unit: mismatch");
      $finish;
    end
  end

  initial begin : receiver_stalls
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_scan_op(input logic [OP_W-1:0] op, input logic pin);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_pin_level <= pin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] charge, input logic [CFG_W-1:0] threshold);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PRECHARGE;
    cfg_data <= charge;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= REG_BLACK_THRESHOLD;
    cfg_data <= threshold;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned r;
    int sent;
    int pin_run;
    logic pin_now;
    logic scanning;
    logic [CFG_W-1:0] ct;
    logic [CFG_W-1:0] bt;
    pin_run = 0;
    pin_now = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: idle tick, unknown opcode, stop from idle
    send_scan_op(OP_TICK, 1'b1);
    send_scan_op(OP_UNUSED, 1'b1);
    send_scan_op(OP_STOP, 1'b0);
    settle();
    // zero threshold must not start a scan or cut the charge short
    load_config(16'd2, 16'd0);
    send_scan_op(OP_TICK, 1'b1);
    send_scan_op(OP_START, 1'b1);
    send_scan_op(OP_TICK, 1'b1);
    send_scan_op(OP_TICK, 1'b1);
    send_scan_op(OP_TICK, 1'b1);
    send_scan_op(OP_TICK, 1'b1);
    send_scan_op(OP_START, 1'b0);
    send_scan_op(OP_TICK, 1'b0);
    send_scan_op(OP_UNUSED, 1'b0);
    send_scan_op(OP_TICK, 1'b0);
    send_scan_op(OP_TICK, 1'b0);
    send_scan_op(OP_TICK, 1'b0);
    send_scan_op(OP_STOP, 1'b1);
    send_scan_op(OP_TICK, 1'b1);
    send_scan_op(OP_START, 1'b0);
    send_scan_op(OP_STOP, 1'b0);
    send_scan_op(OP_START, 1'b1);
    send_scan_op(OP_TICK, 1'b1);

    for (int s = 0; s < SETTINGS_COUNT; s++) begin
      case (s)
        0: begin ct = 16'd0; bt = 16'd0; end
        1: begin ct = 16'd0; bt = 16'd3; end
        2: begin ct = 16'd5; bt = 16'd20; end
        3: begin ct = 16'd3; bt = 16'hFFFF; end
        4: begin ct = PRECHARGE_RST; bt = BLACK_THRESHOLD_RST; end
        default: begin
          ct = CFG_W'($urandom_range(0, 15));
          bt = CFG_W'($urandom_range(0, 40));
        end
      endcase
      settle();
      load_config(ct, bt);
      idling = ($urandom_range(0, 3) != 0);
      scanning = 1'b0;
      sent = 0;
      while (sent < ITEMS_PER_SETTING) begin
        r = $urandom_range(0, 99);
        if ((!scanning && r < 40) || r < 2) begin
          send_scan_op(OP_START, 1'($urandom_range(0, 1)));
          scanning = 1'b1;
          sent++;
        end else if (r < 4) begin
          send_scan_op(OP_STOP, 1'($urandom_range(0, 1)));
          scanning = 1'b0;
          sent++;
        end else if (r < 7) begin
          send_scan_op(OP_UNUSED, 1'($urandom_range(0, 1)));
        end else begin
          // pin stays high for a while, then drops briefly as the capacitor drains
          if (pin_run == 0) begin
            pin_now = ~pin_now;
            pin_run = pin_now ? $urandom_range(1, 48) : $urandom_range(1, 4);
          end
          pin_run--;
          send_scan_op(OP_TICK, pin_now);
          sent++;
        end
      end
    end

    // full-scale charge time and threshold, no idling
    settle();
    idling = 1'b0;
    load_config(16'hFFFF, 16'hFFFF);
    send_scan_op(OP_START, 1'b0);
    repeat (40) send_scan_op(OP_TICK, 1'b1);
    send_scan_op(OP_STOP, 1'b0);
    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("rc_reflectance_sensor_scanner_unit: match");
    else
      $display("rc_reflectance_sensor_scanner_unit: mismatch");
    $finish;
  end

endmodule
